### hdl/assert_macros.svh
// Assertion macros shared by the frame receiver RTL.
// Depends on: nothing; users provide clock and reset signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that holds at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### hdl/sfsp_pkg.sv
// Package for the serial frame to serpentine pixel receiver.
// Holds panel geometry, field widths, parse phase and write types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfsp_pkg;

   localparam int PANEL_COLS   = 81;
   localparam int PANEL_ROWS   = 12;
   localparam int FRAME_PIXELS = PANEL_ROWS * PANEL_COLS;

   localparam int BYTE_W      = 8;
   localparam int LED_INDEX_W = 10;
   localparam int CHAN_W      = 2;
   localparam int LEN_W       = 2 * BYTE_W;
   localparam int ROW_W       = (PANEL_ROWS > 1) ? $clog2(PANEL_ROWS) : 1;
   localparam int COL_W       = $clog2(PANEL_COLS);

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

   localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
   localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
   localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef struct packed {
      logic                   valid;
      logic [LED_INDEX_W-1:0] led_index;
      logic [CHAN_W-1:0]      color_channel;
      logic [BYTE_W-1:0]      color_value;
      logic                   frame_done;
   } pix_wr_type;

endpackage

`default_nettype wire

### hdl/sfsp_parser.sv
// Frame parser: sync hunt, length check and serpentine pixel addressing.
// Depends on sfsp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfsp_parser
   import sfsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_valid,
   input  wire logic [BYTE_W-1:0] rx_byte,
   output pix_wr_type             wr
);

   localparam logic [ROW_W-1:0]       ROW_LAST   = ROW_W'(PANEL_ROWS - 1);
   localparam logic [COL_W-1:0]       COL_LAST   = COL_W'(PANEL_COLS - 1);
   localparam logic [LED_INDEX_W-1:0] ROW_STRIDE = LED_INDEX_W'(PANEL_COLS);
   localparam logic [LEN_W-1:0]       FRAME_LEN  = LEN_W'(FRAME_PIXELS);

   phase_type              phase_ff, phase_in;
   logic [BYTE_W-1:0]      len_lo_ff, len_lo_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [CHAN_W-1:0]      chan_ff, chan_in;
   logic [LED_INDEX_W-1:0] idx_ff, idx_in;

   logic row_end;
   logic last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         len_lo_ff <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         chan_ff   <= CH_RED;
         idx_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         len_lo_ff <= len_lo_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         chan_ff   <= chan_in;
         idx_ff    <= idx_in;
      end
   end

   assign row_end = (col_ff == COL_LAST);
   assign last    = (row_ff == ROW_LAST) && row_end && (chan_ff == CH_BLUE);

   always_comb begin
      phase_in  = phase_ff;
      len_lo_in = len_lo_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      chan_in   = chan_ff;
      idx_in    = idx_ff;

      wr.valid         = 1'b0;
      wr.led_index     = idx_ff;
      wr.color_channel = chan_ff;
      wr.color_value   = rx_byte;
      wr.frame_done    = last;

      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT: begin
               phase_in = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
            PH_SYNC2: begin
               phase_in = (rx_byte == SYNC_SECOND) ? PH_LEN_LO : PH_HUNT;
            end
            PH_LEN_LO: begin
               len_lo_in = rx_byte;
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               if ({rx_byte, len_lo_ff} == FRAME_LEN) begin
                  row_in   = '0;
                  col_in   = '0;
                  chan_in  = CH_RED;
                  idx_in   = '0;
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_PAYLOAD: begin
               wr.valid = 1'b1;
               if (last) begin
                  row_in   = '0;
                  col_in   = '0;
                  chan_in  = CH_RED;
                  idx_in   = '0;
                  phase_in = PH_HUNT;
               end else if (chan_ff != CH_BLUE) begin
                  chan_in = chan_ff + 1'b1;
               end else begin
                  chan_in = CH_RED;
                  if (!row_end) begin
                     col_in = col_ff + 1'b1;
                     // odd rows run backward along the strip
                     idx_in = row_ff[0] ? (idx_ff - 1'b1) : (idx_ff + 1'b1);
                  end else begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                     // row turn: next row starts directly one stride further
                     idx_in = idx_ff + ROW_STRIDE;
                  end
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   `ASSERT_CLK(a_done_on_blue, (wr.valid && wr.frame_done) |-> (wr.color_channel == CH_BLUE),
      "frame_done on a non-blue write")
   `ASSERT_CLK(a_hunt_after_done, (wr.valid && wr.frame_done) |=> (phase_ff == PH_HUNT),
      "parser not hunting after frame end")
   `ASSERT_CLK(a_frame_start, (byte_valid && phase_ff == PH_LEN_HI && {rx_byte, len_lo_ff} == FRAME_LEN) |=> (phase_ff == PH_PAYLOAD && idx_ff == '0 && chan_ff == CH_RED),
      "payload did not start at strip origin")
   `ASSERT_CLK(a_write_only_payload, wr.valid |-> (phase_ff == PH_PAYLOAD && byte_valid),
      "pixel write outside payload")

endmodule

`default_nettype wire

### hdl/serial_frame_to_serpentine_pixels_core.sv
// Top level of the serial frame to serpentine pixel receiver.
// Depends on sfsp_pkg, sfsp_parser and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_led_index, rsp_color_channel,
//           |           |                      | rsp_color_value, rsp_frame_done
//
// One byte per cycle while req_ready is high; a pixel write appears in the cycle after its payload byte transfer.
// The result register is the only stage: req_ready is low only while it holds an untaken write.
// Header and dropped bytes give no write.
// Synchronous active-high reset returns the parser to sync hunting and empties the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module serial_frame_to_serpentine_pixels_core
   import sfsp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [BYTE_W-1:0]      req_rx_byte,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [LED_INDEX_W-1:0] rsp_led_index,
   output      logic [CHAN_W-1:0]      rsp_color_channel,
   output      logic [BYTE_W-1:0]      rsp_color_value,
   output      logic                   rsp_frame_done
);

   pix_wr_type wr;
   logic       rsp_valid_ff;
   pix_wr_type rsp_ff;
   logic       req_xfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   sfsp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_xfer),
      .rx_byte    (req_rx_byte),
      .wr         (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         rsp_ff <= wr;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_index     = rsp_ff.led_index;
   assign rsp_color_channel = rsp_ff.color_channel;
   assign rsp_color_value   = rsp_ff.color_value;
   assign rsp_frame_done    = rsp_ff.frame_done;

   `ASSERT_CLK(a_write_from_byte, (rsp_valid && !$past(rsp_valid)) |-> $past(req_xfer),
      "result appeared without a byte transfer")
   `ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid,
      "result register not emptied by reset")

endmodule

`default_nettype wire

### sim/sfsp_pixel_checker.sv
// Checker for the serial frame to serpentine pixel receiver: predicts pixel writes
// from accepted bytes and compares them with the write channel. Depends on sfsp_pkg.
`timescale 1ns / 1ps

module sfsp_pixel_checker
   import sfsp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic [BYTE_W-1:0]      req_rx_byte,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic [LED_INDEX_W-1:0] rsp_led_index,
   input  wire logic [CHAN_W-1:0]      rsp_color_channel,
   input  wire logic [BYTE_W-1:0]      rsp_color_value,
   input  wire logic                   rsp_frame_done,
   output int                          mismatches,
   output int                          backlog,
   output int                          writes_checked,
   output int                          frames_finished
);

   localparam int COLOR_CHANNELS = 3;

   typedef struct packed {
      logic [LED_INDEX_W-1:0] led_index;
      logic [CHAN_W-1:0]      channel;
      logic [BYTE_W-1:0]      value;
      logic                   done;
   } pixel_write_t;

   pixel_write_t    expected_writes[$];
   pixel_write_t    oldest;
   phase_type       phase = PH_HUNT;
   logic [BYTE_W-1:0] len_lo = '0;
   int unsigned     row = 0;
   int unsigned     col = 0;
   int unsigned     chan = 0;
   int              fail_count = 0;
   int              checked_count = 0;
   int              done_count = 0;
   int              queued = 0;

   assign mismatches      = fail_count;
   assign backlog         = queued;
   assign writes_checked  = checked_count;
   assign frames_finished = done_count;

   function automatic logic [LED_INDEX_W-1:0] strip_position(int unsigned r, int unsigned c);
      logic [31:0] full;
      int unsigned pos;
      pos  = r[0] ? (PANEL_COLS - 1 - c) : c;
      full = r * PANEL_COLS + pos;
      return full[LED_INDEX_W-1:0];
   endfunction

   task automatic report_mismatch(input string note);
      fail_count++;
      if (fail_count <= 30)
         $display("[%0t] pixel write %0d: %s", $time, checked_count, note);
   endtask

   task automatic absorb_byte(input logic [BYTE_W-1:0] b);
      pixel_write_t w;
      logic         last;
      case (phase)
         PH_SYNC2: phase = (b == SYNC_SECOND) ? PH_LEN_LO : PH_HUNT;
         PH_LEN_LO: begin
            len_lo = b;
            phase  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if ({b, len_lo} == FRAME_PIXELS) begin
               row   = 0;
               col   = 0;
               chan  = 0;
               phase = PH_PAYLOAD;
            end else begin
               phase = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            last = (row == PANEL_ROWS - 1) && (col == PANEL_COLS - 1) &&
                   (chan == COLOR_CHANNELS - 1);
            w.led_index = strip_position(row, col);
            w.channel   = chan[CHAN_W-1:0];
            w.value     = b;
            w.done      = last;
            expected_writes.push_back(w);
            if (last) begin
               row   = 0;
               col   = 0;
               chan  = 0;
               phase = PH_HUNT;
            end else if (chan < COLOR_CHANNELS - 1) begin
               chan++;
            end else begin
               chan = 0;
               if (col < PANEL_COLS - 1) begin
                  col++;
               end else begin
                  col = 0;
                  row++;
               end
            end
         end
         default: phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_writes.delete();
         phase  = PH_HUNT;
         len_lo = '0;
         row    = 0;
         col    = 0;
         chan   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               report_mismatch($sformatf("write with none pending (index %0d value %0d)",
                                         rsp_led_index, rsp_color_value));
            end else begin
               oldest = expected_writes.pop_front();
               if (rsp_led_index !== oldest.led_index)
                  report_mismatch($sformatf("led_index got %0d expected %0d",
                                            rsp_led_index, oldest.led_index));
               if (rsp_color_channel !== oldest.channel)
                  report_mismatch($sformatf("color_channel got %0d expected %0d",
                                            rsp_color_channel, oldest.channel));
               if (rsp_color_value !== oldest.value)
                  report_mismatch($sformatf("color_value got %0d expected %0d",
                                            rsp_color_value, oldest.value));
               if (rsp_frame_done !== oldest.done)
                  report_mismatch($sformatf("frame_done got %0b expected %0b",
                                            rsp_frame_done, oldest.done));
               if (oldest.done)
                  done_count++;
               checked_count++;
            end
         end
         if (req_valid && req_ready)
            absorb_byte(req_rx_byte);
      end
      queued <= expected_writes.size();
   end

endmodule

### sim/serial_frame_to_serpentine_pixels_core_test.sv
// Testbench top for serial_frame_to_serpentine_pixels_core: drives header, noise and
// frame payload bytes with bursty valid and stalling ready.
// Depends on sfsp_pkg, sfsp_pixel_checker and serial_frame_to_serpentine_pixels_core.
`timescale 1ns / 1ps

module serial_frame_to_serpentine_pixels_core_test;
   import sfsp_pkg::*;

   typedef enum int {ACCEPT_ALL, ACCEPT_RANDOM, ACCEPT_PERIODIC} accept_pattern_type;

   localparam int TARGET_BYTES = 950;
   localparam int NOISE_BYTES  = 350;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [LED_INDEX_W-1:0] rsp_led_index;
   logic [CHAN_W-1:0]      rsp_color_channel;
   logic [BYTE_W-1:0]      rsp_color_value;
   logic                   rsp_frame_done;

   int mismatches;
   int backlog;
   int writes_checked;
   int frames_finished;

   int                 bytes_sent = 0;
   int                 frames_started = 0;
   int                 headers_dropped = 0;
   int                 burst_left = 1;
   int unsigned        stall_tick = 0;
   accept_pattern_type accept_mode = ACCEPT_ALL;

   serial_frame_to_serpentine_pixels_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_led_index     (rsp_led_index),
      .rsp_color_channel (rsp_color_channel),
      .rsp_color_value   (rsp_color_value),
      .rsp_frame_done    (rsp_frame_done)
   );

   sfsp_pixel_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_led_index     (rsp_led_index),
      .rsp_color_channel (rsp_color_channel),
      .rsp_color_value   (rsp_color_value),
      .rsp_frame_done    (rsp_frame_done),
      .mismatches        (mismatches),
      .backlog           (backlog),
      .writes_checked    (writes_checked),
      .frames_finished   (frames_finished)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure from a randomly chosen accept pattern (all, random or periodic)
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 256 == 0)
         accept_mode <= accept_pattern_type'($urandom_range(0, 2));
      case (accept_mode)
         ACCEPT_ALL:    rsp_ready <= 1'b1;
         ACCEPT_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         default:       rsp_ready <= (stall_tick % 7) < 4;
      endcase
   end

   function automatic int next_burst();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      logic ready_seen;
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do begin
         @(negedge clock);
         ready_seen = req_ready;
         @(posedge clock);
      end while (!ready_seen);
      bytes_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = next_burst();
      end
   endtask

   task automatic drain_writes();
      req_valid <= 1'b0;
      do @(negedge clock); while (backlog != 0);
      @(posedge clock);
      burst_left = next_burst();
   endtask

   task automatic send_header(input logic [LEN_W-1:0] pixels);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(pixels[BYTE_W-1:0]);
      send_byte(pixels[LEN_W-1:BYTE_W]);
   endtask

   initial begin
      int unsigned       pick;
      logic [LEN_W-1:0]  bad_len;
      logic [BYTE_W-1:0] b;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: noise while hunting, bad second sync, wrong lengths
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_SECOND);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(SYNC_FIRST);
      send_byte(8'h00);
      send_header(LEN_W'(0));
      send_header('1);
      send_header(LEN_W'(FRAME_PIXELS - 1));
      send_header(LEN_W'(FRAME_PIXELS + 1));
      headers_dropped += 6;
      drain_writes();

      while (bytes_sent < NOISE_BYTES) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            headers_dropped++;
            if ($urandom_range(0, 1) == 0) begin
               send_byte(SYNC_FIRST);
               if ($urandom_range(0, 2) == 0) begin
                  b = SYNC_FIRST;
               end else begin
                  do b = BYTE_W'($urandom_range(0, 255)); while (b == SYNC_SECOND);
               end
               send_byte(b);
            end else begin
               case ($urandom_range(0, 2))
                  0:       bad_len = LEN_W'(FRAME_PIXELS + ($urandom_range(0, 1) ? 1 : -1));
                  1:       bad_len = {LEN_W'(FRAME_PIXELS)} << BYTE_W |
                                     (LEN_W'(FRAME_PIXELS) >> BYTE_W);
                  default: bad_len = LEN_W'($urandom_range(0, 65535));
               endcase
               if (bad_len == FRAME_PIXELS)
                  bad_len = ~bad_len;
               send_header(bad_len);
            end
         end else begin
            // hunting noise, never a sync start
            repeat ($urandom_range(1, 12)) begin
               do b = BYTE_W'($urandom_range(0, 255)); while (b == SYNC_FIRST);
               send_byte(b);
            end
         end
         if ($urandom_range(0, 9) == 0)
            drain_writes();
      end

      // one frame; the byte budget ends it after a few rows
      send_header(LEN_W'(FRAME_PIXELS));
      frames_started++;
      while (bytes_sent < TARGET_BYTES) begin
         case ($urandom_range(0, 7))
            0:       b = SYNC_FIRST;
            1:       b = SYNC_SECOND;
            default: b = BYTE_W'($urandom_range(0, 255));
         endcase
         send_byte(b);
         if ($urandom_range(0, 63) == 0)
            drain_writes();
      end

      drain_writes();
      repeat (16) @(posedge clock);

      $display("Sent %0d bytes: %0d dropped headers, hunting noise, %0d frame(s) started.",
               bytes_sent, headers_dropped, frames_started);
      $display("Checked %0d pixel writes across several strip rows, %0d frame ends.",
               writes_checked, frames_finished);
      if (mismatches == 0 && backlog == 0) begin
         $display("serial_frame_to_serpentine_pixels_core test passed");
      end else begin
         $display("serial_frame_to_serpentine_pixels_core test failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d writes outstanding", backlog);
      $display("serial_frame_to_serpentine_pixels_core test failed");
      $finish;
   end

endmodule
